// File: rtl/core/lcdws_pkg.sv
package lcdws_pkg;

   // Request kinds
   typedef enum logic [1:0] {
      CMD_INIT  = 2'd0,
      CMD_INSTR = 2'd1,
      CMD_CHAR  = 2'd2,
      CMD_GOTO  = 2'd3
   } lcdws_cmd_type;

   // Configuration register indexes
   typedef enum logic [1:0] {
      CSR_FUNCTION_SET = 2'd0,
      CSR_ENTRY_MODE   = 2'd1,
      CSR_DISPLAY      = 2'd2,
      CSR_UNUSED       = 2'd3
   } lcdws_csr_type;

   localparam int CsrIndexWidth = 2;
   localparam int CsrDataWidth  = 5;
   localparam int WaitWidth     = 15;
   localparam int QueueDepth    = 2;

   localparam logic [WaitWidth-1:0] WAIT_NONE_US = 15'd0;
   localparam logic [WaitWidth-1:0] WAIT_CHAR_US = 15'd100;
   localparam logic [WaitWidth-1:0] WAIT_CMD_US  = 15'd5000;
   localparam logic [WaitWidth-1:0] WAIT_INIT_US = 15'd25000;

   // Instruction codes of the standard controller
   localparam logic [7:0] LCD_WAKE_UP      = 8'h30;
   localparam logic [7:0] LCD_FUNCTION_SET = 8'h20;
   localparam logic [7:0] LCD_ENTRY_MODE   = 8'h04;
   localparam logic [7:0] LCD_DISPLAY_CTRL = 8'h08;
   localparam logic [7:0] LCD_CLEAR        = 8'h01;
   localparam logic [7:0] LCD_SET_DDRAM    = 8'h80;
   localparam logic [7:0] LCD_HIGH_NIBBLE  = 8'hF0;
   localparam logic [7:0] LCD_LOW_NIBBLE   = 8'h0F;

   typedef struct packed {
      logic [1:0] cmd;
      logic [7:0] value;
      logic [5:0] column;
      logic       row;
   } lcdws_req_type;

   typedef struct packed {
      logic                 reg_select;
      logic [7:0]           bus_value;
      logic [WaitWidth-1:0] wait_us;
      logic                 last;
   } lcdws_rsp_type;

   // One classified request as it waits between front and back
   typedef struct packed {
      logic       is_init;
      logic       eight_bit;
      logic       reg_select;
      logic [7:0] byte_value;
   } lcdws_entry_type;

   typedef struct packed {
      logic [4:0] function_set;
      logic [1:0] entry_mode;
      logic [2:0] display;
   } lcdws_opts_type;

endpackage

// File: rtl/core/char_lcd_write_sequencer_unit.sv
// Character LCD write sequencer.
// Requests arrive on the req_ channel (valid/ready); each transfer carries a
// command kind, a byte, a column and a row. Every strobe that the LCD needs
// leaves as one transfer on the rsp_ channel, with the register-select level,
// the bus value, the extra wait in microseconds and a flag on the final strobe
// of the request. The csr_ port writes the three option registers at any
// edge where csr_write is high; they should only change while the block idles.
// A request enters the queue at the edge that takes it, and its first strobe
// is then loaded from the queue head into the output register.
// The strobe generator issues one strobe per cycle while the receiver is
// ready; a request is one strobe in 8-bit mode and two in 4-bit mode, an init
// request seven (8-bit) or sixteen (4-bit). A two-entry queue between the
// classifying front end and the strobe generator lets requests be taken while
// a strobe waits in the output register. When the receiver stalls, the output
// register holds its strobe, the queue fills and req_ready falls.
// Reset clears the option registers, selects 4-bit mode and empties the queue.
module char_lcd_write_sequencer_unit #(
   parameter int QueueDepth = lcdws_pkg::QueueDepth
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  lcdws_pkg::lcdws_req_type              req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output lcdws_pkg::lcdws_rsp_type              rsp_data,
   input  logic                                  csr_write,
   input  logic [lcdws_pkg::CsrIndexWidth-1:0]   csr_index,
   input  logic [lcdws_pkg::CsrDataWidth-1:0]    csr_wdata
);
   import lcdws_pkg::*;

   // Option registers. Writes keep the low bits of each register's width.
   logic [4:0] function_set_ff;
   logic [1:0] entry_mode_ff;
   logic [2:0] display_ff;
   lcdws_opts_type opts;

   logic            queue_full;
   logic            push;
   lcdws_entry_type push_entry;
   logic            pop;
   logic            head_valid;
   lcdws_entry_type head_entry;

   always_ff @(posedge clock) begin
      if (reset) begin
         function_set_ff <= '0;
         entry_mode_ff   <= '0;
         display_ff      <= '0;
      end else if (csr_write) begin
         case (lcdws_csr_type'(csr_index))
            CSR_FUNCTION_SET: function_set_ff <= csr_wdata[4:0];
            CSR_ENTRY_MODE:   entry_mode_ff   <= csr_wdata[1:0];
            CSR_DISPLAY:      display_ff      <= csr_wdata[2:0];
            default:          display_ff      <= display_ff;
         endcase
      end
   end

   assign opts.function_set = function_set_ff;
   assign opts.entry_mode   = entry_mode_ff;
   assign opts.display      = display_ff;

   // The front end classifies each request and keeps the interface mode, which
   // an init request takes from bit 4 of the function set options.
   lcdws_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .mode_option (function_set_ff[4]),
      .queue_full  (queue_full),
      .push        (push),
      .push_entry  (push_entry)
   );

   lcdws_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   // The back end walks through the strobes of the request at the queue head
   // and releases the entry with its final strobe.
   lcdws_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .opts       (opts),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

// File: rtl/core/lcdws_front.sv
module lcdws_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  lcdws_pkg::lcdws_req_type   req_data,
   input  logic                   mode_option,
   input  logic                   queue_full,
   output logic                   push,
   output lcdws_pkg::lcdws_entry_type push_entry
);
   import lcdws_pkg::*;

   logic       eight_bit_ff;
   logic       eight_bit_in;
   logic [6:0] goto_addr;

   assign req_ready = !queue_full;
   assign push      = req_valid && !queue_full;

   // Row two starts at 0x40; the sum stays below 0x80.
   assign goto_addr = {req_data.row, 6'b0} + {1'b0, req_data.column};

   always_comb begin
      eight_bit_in          = eight_bit_ff;
      push_entry.is_init    = 1'b0;
      push_entry.reg_select = 1'b0;
      push_entry.byte_value = req_data.value;
      case (lcdws_cmd_type'(req_data.cmd))
         CMD_INIT: begin
            eight_bit_in       = mode_option;
            push_entry.is_init = 1'b1;
         end
         CMD_INSTR: begin
            push_entry.byte_value = req_data.value;
         end
         CMD_CHAR: begin
            push_entry.reg_select = 1'b1;
         end
         CMD_GOTO: begin
            push_entry.byte_value = LCD_SET_DDRAM | {1'b0, goto_addr};
         end
         default: begin
            push_entry.byte_value = req_data.value;
         end
      endcase
      push_entry.eight_bit = eight_bit_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         eight_bit_ff <= 1'b0;
      end else if (push) begin
         eight_bit_ff <= eight_bit_in;
      end
   end

endmodule

// File: rtl/core/lcdws_queue.sv
module lcdws_queue #(
   parameter int Depth = lcdws_pkg::QueueDepth
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  lcdws_pkg::lcdws_entry_type push_entry,
   input  logic                       pop,
   output logic                       full,
   output logic                       head_valid,
   output lcdws_pkg::lcdws_entry_type head_entry
);
   import lcdws_pkg::*;

   localparam int PtrWidth = $clog2(Depth);
   localparam int CntWidth = $clog2(Depth + 1);

   lcdws_entry_type     slot_ff [Depth];
   logic [PtrWidth-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0] count_ff, count_in;

   assign full       = (count_ff == CntWidth'(Depth));
   assign head_valid = (count_ff != '0);
   assign head_entry = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(Depth - 1)) ? '0 : wr_ptr_ff + PtrWidth'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(Depth - 1)) ? '0 : rd_ptr_ff + PtrWidth'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CntWidth'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CntWidth'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: rtl/core/lcdws_back.sv
module lcdws_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       head_valid,
   input  lcdws_pkg::lcdws_entry_type head_entry,
   input  lcdws_pkg::lcdws_opts_type  opts,
   output logic                       pop,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output lcdws_pkg::lcdws_rsp_type   rsp_data
);
   import lcdws_pkg::*;

   logic [2:0]    init_step_ff, init_step_in;
   logic          phase_ff, phase_in;
   logic          rsp_valid_ff;
   lcdws_rsp_type rsp_data_ff, strobe;
   logic          load;
   logic [7:0]    cur_byte;
   logic [WaitWidth-1:0] cur_wait;
   logic          byte_done;
   logic          seq_done;

   assign load      = head_valid && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Byte and trailing wait of the current init step or plain byte
   always_comb begin
      cur_byte = head_entry.byte_value;
      cur_wait = head_entry.reg_select ? WAIT_CHAR_US : WAIT_CMD_US;
      if (head_entry.is_init) begin
         case (init_step_ff)
            3'd0, 3'd1, 3'd2: begin
               cur_byte = LCD_WAKE_UP;
               cur_wait = WAIT_INIT_US;
            end
            3'd3: begin
               cur_byte = LCD_FUNCTION_SET;
               cur_wait = WAIT_INIT_US;
            end
            3'd4: begin
               cur_byte = LCD_FUNCTION_SET | {3'b0, opts.function_set};
               cur_wait = WAIT_CMD_US;
            end
            3'd5: begin
               cur_byte = LCD_ENTRY_MODE | {6'b0, opts.entry_mode};
               cur_wait = WAIT_CMD_US;
            end
            3'd6: begin
               cur_byte = LCD_DISPLAY_CTRL | {5'b0, opts.display};
               cur_wait = WAIT_CMD_US;
            end
            default: begin
               cur_byte = LCD_CLEAR;
               cur_wait = WAIT_CMD_US;
            end
         endcase
      end
   end

   always_comb begin
      byte_done = head_entry.eight_bit || phase_ff;
      seq_done  = byte_done && (!head_entry.is_init || (init_step_ff == 3'd7));

      strobe.reg_select = head_entry.reg_select;
      strobe.last       = seq_done;
      if (head_entry.eight_bit) begin
         strobe.bus_value = cur_byte;
         strobe.wait_us   = cur_wait;
      end else if (!phase_ff) begin
         strobe.bus_value = cur_byte & LCD_HIGH_NIBBLE;
         strobe.wait_us   = WAIT_NONE_US;
      end else begin
         strobe.bus_value = {cur_byte[3:0] & LCD_LOW_NIBBLE[3:0], 4'b0};
         strobe.wait_us   = cur_wait;
      end

      pop          = load && seq_done;
      phase_in     = phase_ff;
      init_step_in = init_step_ff;
      if (load) begin
         phase_in = !byte_done;
         if (seq_done) begin
            init_step_in = 3'd0;
         end else if (byte_done) begin
            // The extra 0x20 wake-up step belongs to 4-bit mode only.
            init_step_in = (head_entry.eight_bit && init_step_ff == 3'd2) ?
                           3'd4 : init_step_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         phase_ff     <= 1'b0;
         init_step_ff <= 3'd0;
      end else begin
         phase_ff     <= phase_in;
         init_step_ff <= init_step_in;
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_data_ff <= strobe;
      end
   end

endmodule

// File: rtl/core/lcdws_checker.sv
module lcdws_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input lcdws_pkg::lcdws_rsp_type rsp_data
);
   import lcdws_pkg::*;

   // A stalled strobe stays put.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled strobe changed");

   // Nothing is offered right after reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("strobe offered after reset");

   // Only a high-nibble strobe carries no wait, and it never ends a request.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.wait_us == WAIT_NONE_US |-> !rsp_data.last)
      else $error("final strobe without wait");

   // A request ends with the character wait or the instruction wait.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.last |->
         (rsp_data.reg_select && rsp_data.wait_us == WAIT_CHAR_US) ||
         (!rsp_data.reg_select && rsp_data.wait_us == WAIT_CMD_US))
      else $error("wrong wait on final strobe");

endmodule

bind char_lcd_write_sequencer_unit lcdws_checker u_lcdws_checker (.*);

// File: verif/char_lcd_write_sequencer_unit_tb.sv
module char_lcd_write_sequencer_unit_tb;
   import lcdws_pkg::*;

   // Cycles without any transfer on either channel before the run is given up.
   localparam int StallLimit = 1000;
   // Cycles allowed after the last due strobe before the block counts as idle.
   localparam int SettleCycles = 4;

   // Scoreboard: it mirrors the option registers and the interface mode, turns
   // every request taken by the block into the strobes that it must cause, and
   // compares each strobe transfer with the oldest one still due.
   class lcd_strobe_scoreboard;
      localparam logic [7:0] SecondRowBase = 8'h40;

      lcdws_rsp_type strobes_due[$];
      logic [4:0]    function_set;
      logic [1:0]    entry_mode;
      logic [2:0]    display;
      logic          eight_bit;
      int            errors;

      function new();
         function_set = '0;
         entry_mode   = '0;
         display      = '0;
         eight_bit    = 1'b0;
         errors       = 0;
      endfunction

      task report(string msg);
         errors++;
         $display("MISMATCH at %0t: %s", $realtime, msg);
      endtask

      // Writes keep only the low bits of each register; the spare index is ignored.
      function void set_option(lcdws_csr_type idx, logic [CsrDataWidth-1:0] data);
         case (idx)
            CSR_FUNCTION_SET: function_set = data;
            CSR_ENTRY_MODE:   entry_mode   = data[1:0];
            CSR_DISPLAY:      display      = data[2:0];
            default: ;
         endcase
      endfunction

      // One byte is one strobe in 8-bit mode, or a high and a low nibble on
      // bus bits 7:4 in 4-bit mode, with the extra wait on the second only.
      function void queue_byte(logic rs, logic [7:0] b, logic [WaitWidth-1:0] extra_us,
                               logic tail);
         lcdws_rsp_type s;
         if (eight_bit) begin
            s = '{rs, b, extra_us, tail};
            strobes_due.push_back(s);
         end else begin
            s = '{rs, b & LCD_HIGH_NIBBLE, WAIT_NONE_US, 1'b0};
            strobes_due.push_back(s);
            s = '{rs, 8'((b & LCD_LOW_NIBBLE) << 4), extra_us, tail};
            strobes_due.push_back(s);
         end
      endfunction

      function void note_request(lcdws_req_type r);
         logic [7:0] addr;
         case (lcdws_cmd_type'(r.cmd))
            CMD_INIT: begin
               // The mode is latched first, so the wake-up bytes already use it.
               eight_bit = function_set[4];
               repeat (3) queue_byte(1'b0, LCD_WAKE_UP, WAIT_INIT_US, 1'b0);
               if (!eight_bit)
                  queue_byte(1'b0, LCD_FUNCTION_SET, WAIT_INIT_US, 1'b0);
               queue_byte(1'b0, LCD_FUNCTION_SET | 8'(function_set), WAIT_CMD_US, 1'b0);
               queue_byte(1'b0, LCD_ENTRY_MODE | 8'(entry_mode), WAIT_CMD_US, 1'b0);
               queue_byte(1'b0, LCD_DISPLAY_CTRL | 8'(display), WAIT_CMD_US, 1'b0);
               queue_byte(1'b0, LCD_CLEAR, WAIT_CMD_US, 1'b1);
            end
            CMD_INSTR: queue_byte(1'b0, r.value, WAIT_CMD_US, 1'b1);
            CMD_CHAR:  queue_byte(1'b1, r.value, WAIT_CHAR_US, 1'b1);
            default: begin
               addr = (r.row ? SecondRowBase : 8'h00) + 8'(r.column);
               queue_byte(1'b0, LCD_SET_DDRAM | addr, WAIT_CMD_US, 1'b1);
            end
         endcase
      endfunction

      task check_strobe(lcdws_rsp_type got);
         lcdws_rsp_type want;
         if (strobes_due.size() == 0) begin
            report($sformatf("strobe %h arrived with nothing due", got));
            return;
         end
         want = strobes_due.pop_front();
         if (got.reg_select !== want.reg_select)
            report($sformatf("reg_select %b, expected %b", got.reg_select, want.reg_select));
         if (got.bus_value !== want.bus_value)
            report($sformatf("bus_value %h, expected %h", got.bus_value, want.bus_value));
         if (got.wait_us !== want.wait_us)
            report($sformatf("wait_us %0d, expected %0d", got.wait_us, want.wait_us));
         if (got.last !== want.last)
            report($sformatf("last %b, expected %b", got.last, want.last));
      endtask
   endclass

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     req_valid;
   logic                     req_ready;
   lcdws_req_type            req_data;
   logic                     rsp_valid;
   logic                     rsp_ready;
   lcdws_rsp_type            rsp_data;
   logic                     csr_write;
   logic [CsrIndexWidth-1:0] csr_index;
   logic [CsrDataWidth-1:0]  csr_wdata;

   lcd_strobe_scoreboard sb;
   // When set, neither side idles; the last part of the run goes at full rate.
   bit calm;
   int idle_cycles;

   char_lcd_write_sequencer_unit uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // The receiver stalls in random bursts. Each pass of the loop makes at most
   // one assignment to rsp_ready per clock edge.
   initial begin
      forever begin
         @(posedge clock);
         if (!calm && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   // Strobe transfers are checked at the edge at which they happen; the values
   // seen here are those from before the edge, as the block saw them.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready)
            sb.check_strobe(rsp_data);
         if ((rsp_valid && rsp_ready) || (req_valid && req_ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      wait (idle_cycles >= StallLimit);
      $display("Regression FAIL");
      $finish;
   end

   function automatic lcdws_req_type lcd_req(lcdws_cmd_type cmd, logic [7:0] value,
                                             logic [5:0] column, logic row);
      lcdws_req_type r;
      r = '{cmd, value, column, row};
      return r;
   endfunction

   // Fully random content; init requests are kept rare as each one is long.
   function automatic lcdws_req_type random_request();
      lcdws_req_type r;
      logic [31:0]   raw;
      raw = $urandom;
      r = raw[$bits(lcdws_req_type)-1:0];
      r.cmd = ($urandom_range(0, 11) == 0) ? CMD_INIT : lcdws_cmd_type'($urandom_range(1, 3));
      return r;
   endfunction

   // Offers one request, possibly after a short gap, and waits for its
   // transfer. Valid is left high: the next call either replaces the payload
   // or opens a gap, and drain lowers it, so it is assigned once per edge.
   task automatic send_request(lcdws_req_type r);
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_data  <= r;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_request(r);
   endtask

   // Holds the sender back until every due strobe has arrived, then lets the
   // block settle so that option writes find it idle.
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.strobes_due.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   // Writes all three option registers and the spare index, which should have
   // no effect. Only called once the block has drained.
   task automatic configure(logic [CsrDataWidth-1:0] fs, logic [CsrDataWidth-1:0] em,
                            logic [CsrDataWidth-1:0] dp);
      logic [CsrDataWidth-1:0] data [4];
      lcdws_csr_type           idx;
      int                      i;
      data = '{fs, em, dp, CsrDataWidth'($urandom)};
      for (i = 0; i < 4; i++) begin
         idx = lcdws_csr_type'(i);
         csr_write <= 1'b1;
         csr_index <= idx;
         csr_wdata <= data[i];
         @(posedge clock);
         sb.set_option(idx, data[i]);
      end
      csr_write <= 1'b0;
   endtask

   initial begin
      int phase;
      int n;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      rsp_ready   = 1'b0;
      csr_write   = 1'b0;
      csr_index   = '0;
      csr_wdata   = '0;
      calm        = 1'b0;
      idle_cycles = 0;
      sb = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Before any init the block is in its reset 4-bit mode.
      send_request(lcd_req(CMD_INSTR, 8'h00, 6'd0, 1'b0));
      send_request(lcd_req(CMD_CHAR, 8'hFF, 6'd63, 1'b1));
      send_request(lcd_req(CMD_GOTO, 8'hFF, 6'd63, 1'b1));
      send_request(lcd_req(CMD_GOTO, 8'h00, 6'd0, 1'b0));

      // Full 4-bit init with every other option bit set.
      drain();
      configure(5'h0F, 5'h03, 5'h07);
      send_request(lcd_req(CMD_INIT, 8'h00, 6'd0, 1'b0));
      send_request(lcd_req(CMD_INSTR, 8'hA5, 6'd21, 1'b1));
      send_request(lcd_req(CMD_CHAR, 8'h5A, 6'd42, 1'b0));
      send_request(lcd_req(CMD_GOTO, 8'h3C, 6'd0, 1'b1));

      // 8-bit init; the oversized writes must be cut to the register widths.
      drain();
      configure(5'h1F, 5'h1F, 5'h1F);
      send_request(lcd_req(CMD_INIT, 8'hFF, 6'd63, 1'b1));
      send_request(lcd_req(CMD_CHAR, 8'h00, 6'd0, 1'b0));
      send_request(lcd_req(CMD_CHAR, 8'hFF, 6'd0, 1'b0));
      send_request(lcd_req(CMD_INSTR, 8'h80, 6'd63, 1'b1));
      send_request(lcd_req(CMD_GOTO, 8'h00, 6'd63, 1'b1));
      send_request(lcd_req(CMD_GOTO, 8'h00, 6'd42, 1'b0));

      // 8-bit init with all other options clear.
      drain();
      configure(5'h10, 5'h00, 5'h00);
      send_request(lcd_req(CMD_INIT, 8'h00, 6'd0, 1'b0));
      send_request(lcd_req(CMD_CHAR, 8'h81, 6'd0, 1'b0));

      // Clearing the mode bit changes nothing until the next init request.
      drain();
      configure(5'h00, 5'h00, 5'h00);
      send_request(lcd_req(CMD_CHAR, 8'h3C, 6'd5, 1'b0));
      send_request(lcd_req(CMD_INIT, 8'h00, 6'd0, 1'b0));
      send_request(lcd_req(CMD_CHAR, 8'hC3, 6'd5, 1'b1));

      // Random part in four phases, each with fresh options. The second phase
      // pauses halfway until the block has caught up; the last runs calm.
      for (phase = 0; phase < 4; phase++) begin
         drain();
         if (phase == 3)
            calm = 1'b1;
         configure(CsrDataWidth'($urandom), CsrDataWidth'($urandom),
                   CsrDataWidth'($urandom));
         if ($urandom_range(0, 1) == 0)
            send_request(lcd_req(CMD_INIT, 8'($urandom), 6'($urandom), 1'($urandom)));
         for (n = 0; n < 40; n++) begin
            if (phase == 1 && n == 20)
               drain();
            send_request(random_request());
         end
      end

      drain();
      if (sb.strobes_due.size() != 0)
         sb.report($sformatf("%0d strobes never arrived", sb.strobes_due.size()));
      if (sb.errors == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
